// ----- hw/rtl/afu_pkg.sv -----
// Shared constants, operation codes and the sideband type of the activation unit.
// Used by afu_div and activation_function_unit_top; depends on nothing else.
package afu_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int CB     = 24;

  // Operation codes of the func field.
  localparam logic [2:0] FN_GELU = 3'd0;
  localparam logic [2:0] FN_ERF  = 3'd1;
  localparam logic [2:0] FN_TANH = 3'd2;
  localparam logic [2:0] FN_SIG  = 3'd3;
  localparam logic [2:0] FN_MAX  = 3'd4;

  // Coefficients held as round(c * 2^24).
  localparam logic signed [25:0] K_G_SLOPE = 26'sd5149313;
  localparam logic signed [25:0] K_G_OFS   = 26'sd8405385;
  localparam logic signed [25:0] K_G_MAX   = 26'sd16810770;
  localparam logic signed [25:0] K_G_SCALE = 26'sd16739115;
  localparam logic signed [25:0] K_E_GAIN  = 26'sd18568586;
  localparam logic signed [25:0] K_E_CUBE  = 26'sd575425;
  localparam logic signed [25:0] K_E_DSQ   = 26'sd6343281;
  localparam logic signed [25:0] K_E_D0    = 26'sd16693330;
  localparam logic signed [25:0] K_T_GAIN  = 26'sd15099847;
  localparam logic signed [25:0] K_T_CUBE  = 26'sd899913;
  localparam logic signed [25:0] K_T_DSQ   = 26'sd5756951;
  localparam logic signed [25:0] K_T_D0    = 26'sd15119963;
  // GELU offset 0.004004 rounded to the output fraction width.
  localparam logic signed [35:0] K_G_BIAS_F = 36'sd262;

  localparam logic signed [31:0] LIM_2 = 32'sd131072;
  localparam logic signed [31:0] LIM_3 = 32'sd196608;
  localparam logic signed [31:0] LIM_4 = 32'sd262144;
  localparam logic signed [31:0] LIM_6 = 32'sd393216;

  // Divider: 28-bit quotient, two bits per stage.
  localparam int DIV_W     = 28;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int LATENCY   = 8 + DIV_STEPS;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] alt;
    logic               last;
  } sb_t;

endpackage

// ----- hw/rtl/afu_div.sv -----
// Pipelined restoring divider: round(|num| * 2^24 / den), two quotient bits per stage.
// Depends on afu_pkg for widths and the sideband type.
module afu_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [28:0]             in_num,
  input  logic [afu_pkg::DIV_W-1:0]      in_den,
  input  afu_pkg::sb_t                   in_sb,
  output logic                           out_vld,
  output logic [afu_pkg::DIV_W-1:0]      out_q,
  output logic                           out_neg,
  output afu_pkg::sb_t                   out_sb
);

  localparam int W = afu_pkg::DIV_W;
  localparam int S = afu_pkg::DIV_STEPS;

  logic               vld_r [0:S];
  logic [W-1:0]       rem_r [0:S];
  logic [W-1:0]       low_r [0:S];
  logic [W-1:0]       q_r   [0:S];
  logic [W-1:0]       den_r [0:S];
  logic               neg_r [0:S];
  afu_pkg::sb_t       sb_r  [0:S];

  logic [W-1:0]       mag;
  logic [52:0]        dvd_nxt;

  // The dividend carries half the divisor so the quotient rounds to nearest.
  always_comb begin
    mag     = in_num[28] ? W'(-in_num) : W'(in_num);
    dvd_nxt = {1'b0, mag, 24'b0} + 53'(in_den >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= W'(dvd_nxt[52:W]);
    low_r[0] <= dvd_nxt[W-1:0];
    q_r[0]   <= '0;
    den_r[0] <= in_den;
    neg_r[0] <= in_num[28];
    sb_r[0]  <= in_sb;
  end

  for (genvar s = 0; s < S; s++) begin : g_step
    logic [W:0]   sh1, sh2;
    logic [W-1:0] r1, r2;
    logic         b1, b2;

    always_comb begin
      sh1 = {rem_r[s], low_r[s][W-1]};
      b1  = sh1 >= {1'b0, den_r[s]};
      r1  = b1 ? W'(sh1 - {1'b0, den_r[s]}) : sh1[W-1:0];
      sh2 = {r1, low_r[s][W-2]};
      b2  = sh2 >= {1'b0, den_r[s]};
      r2  = b2 ? W'(sh2 - {1'b0, den_r[s]}) : sh2[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1] <= r2;
      low_r[s+1] <= {low_r[s][W-3:0], 2'b00};
      q_r[s+1]   <= {q_r[s][W-3:0], b1, b2};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
      sb_r[s+1]  <= sb_r[s];
    end
  end

  assign out_vld = vld_r[S];
  assign out_q   = q_r[S];
  assign out_neg = neg_r[S];
  assign out_sb  = sb_r[S];

  // The final remainder stays below a nonzero divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S] && den_r[S] != '0 |-> rem_r[S] < den_r[S])
    else $error("divider remainder not below divisor");

  a_vld_flow: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S] |-> $past(in_vld, S + 1))
    else $error("divider output without matching input");

  a_sb_flow: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S] |-> out_sb.last == $past(in_sb.last, S + 1))
    else $error("divider sideband out of step");

endmodule

// ----- hw/rtl/activation_function_unit_top.sv -----
// Activation unit top level: GELU, erf, tanh, sigmoid and max on Q16.16 values.
// Depends on afu_pkg and afu_div.
// Pipeline from the accepting edge to the out_valid strobe: front stages,
// 15 divider stages, gain multiply, output register. Throughput: one item per cycle;
// busy is always low. Synchronous active-low reset clears all valid bits.
module activation_function_unit_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_func,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_other,
  input  logic                in_last_in,
  output logic                out_valid,
  output logic signed [31:0]  out_y,
  output logic                out_last_out
);

  localparam logic signed [63:0] RND = 64'sd8388608;

  // Stage A: input register.
  logic vld_a_r;
  logic [2:0] func_a_r;
  logic signed [31:0] x_a_r, oth_a_r;
  logic last_a_r;

  // Stage B: clamped operands.
  logic vld_b_r, vld_b_nxt;
  logic signed [26:0] c_b_r, c_b_nxt;
  logic signed [27:0] xq_b_r, xq_b_nxt;
  logic signed [31:0] x_b_r;
  afu_pkg::sb_t sb_b_r, sb_b_nxt;

  // Stage C: square and GELU gate.
  logic vld_c_r;
  logic signed [26:0] c_c_r;
  logic signed [28:0] t_c_r, t_c_nxt;
  logic signed [25:0] u_c_r, u_c_nxt;
  logic signed [31:0] x_c_r;
  afu_pkg::sb_t sb_c_r;

  // Stage D: cube, denominator term, GELU product.
  logic vld_d_r;
  logic signed [26:0] c_d_r;
  logic signed [30:0] ct_d_r, ct_d_nxt;
  logic signed [28:0] dt_d_r, dt_d_nxt;
  logic signed [32:0] p_d_r, p_d_nxt;
  afu_pkg::sb_t sb_d_r;

  // Stage E: numerator, denominator, GELU result.
  logic vld_e_r;
  logic signed [28:0] num_e_r, num_e_nxt;
  logic [afu_pkg::DIV_W-1:0] den_e_r, den_e_nxt;
  afu_pkg::sb_t sb_e_r, sb_e_nxt;

  // Divider output.
  logic dv_vld;
  logic [afu_pkg::DIV_W-1:0] dv_q;
  logic dv_neg;
  afu_pkg::sb_t dv_sb;

  // Stage G: gain.
  logic vld_g_r;
  logic signed [31:0] r_g_r, r_g_nxt;
  afu_pkg::sb_t sb_g_r;

  // Output register.
  logic vld_o_r;
  logic signed [31:0] y_o_r, y_o_nxt;
  logic last_o_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_g_r <= 1'b0;
      vld_o_r <= 1'b0;
    end else begin
      vld_a_r <= start && !busy;
      vld_b_r <= vld_b_nxt;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
      vld_g_r <= dv_vld;
      vld_o_r <= vld_g_r;
    end
  end

  always_ff @(posedge clk) begin
    func_a_r <= in_func;
    x_a_r    <= in_x;
    oth_a_r  <= in_other;
    last_a_r <= in_last_in;
  end

  // Stage B logic.
  always_comb begin
    logic signed [31:0] lim, xc, xg;
    vld_b_nxt = vld_a_r;
    case (func_a_r)
      afu_pkg::FN_ERF:  lim = afu_pkg::LIM_2;
      afu_pkg::FN_TANH: lim = afu_pkg::LIM_3;
      afu_pkg::FN_SIG:  lim = afu_pkg::LIM_6;
      default:          lim = '0;
    endcase
    xc = (x_a_r > lim) ? lim : ((x_a_r < -lim) ? -lim : x_a_r);
    // Sigmoid evaluates tanh at x/2, so it moves one bit less.
    c_b_nxt = (func_a_r == afu_pkg::FN_SIG) ? 27'(xc <<< 7) : 27'(xc <<< 8);
    xg = (x_a_r > afu_pkg::LIM_4) ? afu_pkg::LIM_4 :
         ((x_a_r < -afu_pkg::LIM_4) ? -afu_pkg::LIM_4 : x_a_r);
    xq_b_nxt = 28'(xg <<< 8);
    sb_b_nxt.func = func_a_r;
    sb_b_nxt.last = last_a_r;
    if (func_a_r == afu_pkg::FN_MAX) begin
      sb_b_nxt.alt = (x_a_r > oth_a_r) ? x_a_r : oth_a_r;
    end else begin
      sb_b_nxt.alt = '0;
    end
  end

  always_ff @(posedge clk) begin
    c_b_r  <= c_b_nxt;
    xq_b_r <= xq_b_nxt;
    x_b_r  <= x_a_r;
    sb_b_r <= sb_b_nxt;
  end

  // Stage C logic.
  always_comb begin
    logic signed [53:0] pc, pg;
    logic signed [29:0] g;
    pc = 54'(c_b_r) * 54'(c_b_r) + 54'(RND);
    t_c_nxt = 29'(pc >>> 24);
    pg = 54'(xq_b_r) * 54'(afu_pkg::K_G_SLOPE) + 54'(RND);
    g = 30'(pg >>> 24) + 30'(afu_pkg::K_G_OFS);
    if (g < 30'sd0) begin
      u_c_nxt = '0;
    end else if (g > 30'(afu_pkg::K_G_MAX)) begin
      u_c_nxt = afu_pkg::K_G_MAX;
    end else begin
      u_c_nxt = 26'(g);
    end
  end

  always_ff @(posedge clk) begin
    c_c_r  <= c_b_r;
    t_c_r  <= t_c_nxt;
    u_c_r  <= u_c_nxt;
    x_c_r  <= x_b_r;
    sb_c_r <= sb_b_r;
  end

  // Stage D logic.
  always_comb begin
    logic signed [55:0] pct;
    logic signed [54:0] pdt;
    logic signed [57:0] pp;
    logic signed [25:0] d2;
    d2 = (sb_c_r.func == afu_pkg::FN_ERF) ? afu_pkg::K_E_DSQ : afu_pkg::K_T_DSQ;
    pct = 56'(c_c_r) * 56'(t_c_r) + 56'(RND);
    ct_d_nxt = 31'(pct >>> 24);
    pdt = 55'(t_c_r) * 55'(d2) + 55'(RND);
    dt_d_nxt = 29'(pdt >>> 24);
    pp = 58'(x_c_r) * 58'(u_c_r) + 58'(RND);
    p_d_nxt = 33'(pp >>> 24);
  end

  always_ff @(posedge clk) begin
    c_d_r  <= c_c_r;
    ct_d_r <= ct_d_nxt;
    dt_d_r <= dt_d_nxt;
    p_d_r  <= p_d_nxt;
    sb_d_r <= sb_c_r;
  end

  // Stage E logic.
  always_comb begin
    logic signed [56:0] pk;
    logic signed [58:0] ps;
    logic signed [35:0] gy;
    logic signed [25:0] k3, d0;
    if (sb_d_r.func == afu_pkg::FN_ERF) begin
      k3 = afu_pkg::K_E_CUBE;
      d0 = afu_pkg::K_E_D0;
    end else begin
      k3 = afu_pkg::K_T_CUBE;
      d0 = afu_pkg::K_T_D0;
    end
    pk = 57'(ct_d_r) * 57'(k3) + 57'(RND);
    num_e_nxt = 29'(c_d_r) + 29'(pk >>> 24);
    den_e_nxt = afu_pkg::DIV_W'(29'(d0) + dt_d_r);
    ps = 59'(p_d_r) * 59'(afu_pkg::K_G_SCALE) + 59'(RND);
    gy = 36'(ps >>> 24) - afu_pkg::K_G_BIAS_F;
    sb_e_nxt = sb_d_r;
    if (sb_d_r.func == afu_pkg::FN_GELU) begin
      if (gy > 36'sd2147483647) begin
        sb_e_nxt.alt = 32'sh7fffffff;
      end else if (gy < -36'sd2147483648) begin
        sb_e_nxt.alt = 32'sh80000000;
      end else begin
        sb_e_nxt.alt = 32'(gy);
      end
    end
  end

  always_ff @(posedge clk) begin
    num_e_r <= num_e_nxt;
    den_e_r <= den_e_nxt;
    sb_e_r  <= sb_e_nxt;
  end

  afu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_e_r),
    .in_num  (num_e_r),
    .in_den  (den_e_r),
    .in_sb   (sb_e_r),
    .out_vld (dv_vld),
    .out_q   (dv_q),
    .out_neg (dv_neg),
    .out_sb  (dv_sb)
  );

  // Stage G logic: signed quotient times output gain.
  always_comb begin
    logic signed [28:0] qs;
    logic signed [54:0] pr;
    logic signed [25:0] gain;
    gain = (dv_sb.func == afu_pkg::FN_ERF) ? afu_pkg::K_E_GAIN : afu_pkg::K_T_GAIN;
    qs = dv_neg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
    pr = 55'(qs) * 55'(gain) + 55'(RND);
    r_g_nxt = 32'(pr >>> 24);
  end

  always_ff @(posedge clk) begin
    r_g_r  <= r_g_nxt;
    sb_g_r <= dv_sb;
  end

  // Output selection and rounding to 16 fraction bits.
  always_comb begin
    case (sb_g_r.func)
      afu_pkg::FN_ERF, afu_pkg::FN_TANH: y_o_nxt = (r_g_r + 32'sd128) >>> 8;
      afu_pkg::FN_SIG: y_o_nxt = (r_g_r + 32'sd16777216 + 32'sd256) >>> 9;
      default:         y_o_nxt = sb_g_r.alt;
    endcase
  end

  always_ff @(posedge clk) begin
    y_o_r    <= y_o_nxt;
    last_o_r <= sb_g_r.last;
  end

  assign out_valid    = vld_o_r;
  assign out_y        = y_o_r;
  assign out_last_out = last_o_r;

  a_out_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, afu_pkg::LATENCY))
    else $error("result without an accepted transfer");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_out == $past(in_last_in, afu_pkg::LATENCY))
    else $error("last marker out of step");

  a_max_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_func, afu_pkg::LATENCY) == afu_pkg::FN_MAX |->
      out_y == (($past(in_x, afu_pkg::LATENCY) > $past(in_other, afu_pkg::LATENCY)) ?
                $past(in_x, afu_pkg::LATENCY) : $past(in_other, afu_pkg::LATENCY)))
    else $error("max result wrong");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_func, afu_pkg::LATENCY) == 3'd5 ||
                  $past(in_func, afu_pkg::LATENCY) == 3'd6 ||
                  $past(in_func, afu_pkg::LATENCY) == 3'd7) |-> out_y == '0)
    else $error("unused operation gave nonzero result");

endmodule

// ----- tb/sv/activation_function_unit_top_test.sv -----
// Testbench for activation_function_unit_top: directed and random transfers
// checked against an in-bench fixed-point predictor. Depends on afu_pkg and the RTL.
module activation_function_unit_top_test;

  localparam longint ONE_Q = 64'sd1 << afu_pkg::CB;

  // Floor division by a power of two.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul_coef(longint v, longint c);
    longint hi, lo;
    hi = v >>> afu_pkg::CB;
    lo = v - hi * ONE_Q;
    return hi * c + ((lo * c + (ONE_Q >>> 1)) >>> afu_pkg::CB);
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag * ONE_Q + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint ratio_cubic(longint c, longint gain, longint k3, longint d2,
                                         longint d0);
    longint t, num, den;
    t = mul_coef(c, c);
    num = c + mul_coef(mul_coef(c, t), k3);
    den = d0 + mul_coef(t, d2);
    return mul_coef(div_round(num, den), gain);
  endfunction

  function automatic longint tanh_q24(longint c);
    c = clip(c, -3 * ONE_Q, 3 * ONE_Q);
    return ratio_cubic(c, afu_pkg::K_T_GAIN, afu_pkg::K_T_CUBE, afu_pkg::K_T_DSQ,
                       afu_pkg::K_T_D0);
  endfunction

  function automatic logic signed [31:0] activation(logic [2:0] fn, logic signed [31:0] xi,
                                                    logic signed [31:0] oi);
    longint x, one_f, y, xc, u, c, sh;
    x = xi;
    one_f = 64'sd1 << afu_pkg::FRAC_W;
    sh = afu_pkg::CB - afu_pkg::FRAC_W;
    case (fn)
      afu_pkg::FN_GELU: begin
        xc = clip(x, -4 * one_f, 4 * one_f);
        u = clip(mul_coef(xc <<< sh, afu_pkg::K_G_SLOPE) + afu_pkg::K_G_OFS, 0,
                 afu_pkg::K_G_MAX);
        y = mul_coef(mul_coef(x, u), afu_pkg::K_G_SCALE) - afu_pkg::K_G_BIAS_F;
      end
      afu_pkg::FN_ERF: begin
        c = clip(x, -2 * one_f, 2 * one_f) <<< sh;
        y = round_shift(ratio_cubic(c, afu_pkg::K_E_GAIN, afu_pkg::K_E_CUBE,
                                    afu_pkg::K_E_DSQ, afu_pkg::K_E_D0), sh);
      end
      afu_pkg::FN_TANH: y = round_shift(tanh_q24(clip(x, -3 * one_f, 3 * one_f) <<< sh), sh);
      afu_pkg::FN_SIG: begin
        c = floor_shift(clip(x, -6 * one_f, 6 * one_f) <<< sh, 1);
        y = round_shift(ONE_Q + tanh_q24(c), sh + 1);
      end
      afu_pkg::FN_MAX: y = (xi > oi) ? x : longint'(oi);
      default: y = 0;
    endcase
    return 32'(clip(y, -(64'sd1 << 31), (64'sd1 << 31) - 1));
  endfunction

  typedef struct {
    logic signed [31:0] y;
    logic               last;
  } act_result_t;

  class act_scoreboard;
    act_result_t pending[$];
    int errors;

    function void note_input(logic [2:0] fn, logic signed [31:0] x, logic signed [31:0] o,
                             logic l);
      act_result_t r;
      r.y = activation(fn, x, o);
      r.last = l;
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] y, logic l);
      act_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected result y=%0d last=%0b", y, l);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (r.y !== y) begin
        $error("y: expected %0d, actual %0d", r.y, y);
        errors++;
      end
      if (r.last !== l) begin
        $error("last_out: expected %0b, actual %0b", r.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0, busy;
  logic [2:0] in_func = '0;
  logic signed [31:0] in_x = '0, in_other = '0;
  logic in_last_in = 0, out_valid, out_last_out;
  logic signed [31:0] out_y;
  act_scoreboard sb = new();
  int cycles = 0;

  activation_function_unit_top dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && start && !busy) sb.note_input(in_func, in_x, in_other, in_last_in);
    if (rst_n && out_valid) sb.check_result(out_y, out_last_out);
    if (cycles > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Holds one transfer on the inputs until it is accepted.
  task automatic send(logic [2:0] fn, logic signed [31:0] x, logic signed [31:0] o, logic l);
    start <= 1;
    in_func <= fn;
    in_x <= x;
    in_other <= o;
    in_last_in <= l;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $signed($urandom_range(16 * 65536)) - 8 * 65536;
      2: return $signed($urandom_range(1024)) - 512;
      default: return $signed($urandom_range(14 * 65536)) - 7 * 65536;
    endcase
  endfunction

  initial begin
    logic signed [31:0] edges[8];
    int burst, gap;
    edges = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 196608, -196608, 131072};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Extremes for each operation plus unused codes.
    for (int f = 0; f < 8; f++)
      for (int i = 0; i < 3; i++)
        send(3'(f), edges[(f + i * 3) % 8], edges[(f + i * 5 + 1) % 8], 1'(i));
    send(afu_pkg::FN_MAX, 32'sh80000000, 32'sh7fffffff, 0);
    pause(3);
    for (int n = 0; n < 850; ) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n < 850; k++, n++)
        send(($urandom_range(15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4)),
             rand_operand(), rand_operand(), 1'($urandom_range(1)));
      // A zero gap keeps start high so the next burst follows back to back.
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) pause(gap);
    end
    pause(0);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (afu_pkg::LATENCY + 10) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
